>>> design/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants for the replacement template tokenizer
// Holds the beat types of both channels, the parser mode encoding, token and
// error codes, and the character constants that the parser tests against.
// ----------------------------------------------------------------------------
package rtt_pkg;

    // Default width of the saturating capture group counter.
    localparam int GROUP_BITS_DEF = 16;

    // Depth of the token queue ahead of the output port.
    localparam int QUEUE_DEPTH = 4;

    // Characters with a special meaning in a replacement template.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Token kinds.
    localparam logic [1:0] TOK_LITERAL = 2'd0;
    localparam logic [1:0] TOK_CAPTURE = 2'd1;
    localparam logic [1:0] TOK_ERROR   = 2'd2;

    // Error kinds.
    localparam logic [1:0] ERR_VARIABLE = 2'd0;
    localparam logic [1:0] ERR_BRACE    = 2'd1;
    localparam logic [1:0] ERR_NAMED    = 2'd2;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_LIT,
        MODE_DOLLAR,
        MODE_NUM,
        MODE_BSTART,
        MODE_BNAME,
        MODE_BNUM,
        MODE_DROP
    } mode_t;

    // One template character.
    typedef struct packed {
        logic [7:0] template_byte;
        logic       final_byte;
    } template_t;

    // One emitted token.
    typedef struct packed {
        logic [1:0]  token_kind;
        logic [7:0]  literal_value;
        logic [15:0] group_number;
        logic [1:0]  error_kind;
        logic        template_done;
    } token_t;

    // Tokens produced for one character, handed from parser to queue.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

endpackage

>>> design/rtt_parse.sv
// ----------------------------------------------------------------------------
// rtt_parse: template parser state machine
// Holds the parse mode and the group accumulator, and turns one registered
// template character into zero, one or two tokens combinationally.
// ----------------------------------------------------------------------------
module rtt_parse #(
    parameter int GROUP_BITS = rtt_pkg::GROUP_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  rtt_pkg::template_t item,
    output rtt_pkg::push_t     push
);
    import rtt_pkg::*;

    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic [GROUP_BITS-1:0]  acc_reg;
    logic [GROUP_BITS-1:0]  acc_next;

    logic [7:0]             c;
    logic                   fin;
    logic                   is_digit;
    logic                   is_name;
    logic [GROUP_BITS+3:0]  digit_ext;
    logic [GROUP_BITS+3:0]  acc_ext;
    logic [GROUP_BITS+3:0]  sum_wide;
    logic [GROUP_BITS-1:0]  acc_sum;
    logic [GROUP_BITS-1:0]  digit_val;

    // Build a token; fields that do not belong to the kind are zero.
    function automatic token_t mk_lit(logic [7:0] lit, logic done);
        token_t t;
        t = '0;
        t.token_kind = TOK_LITERAL;
        t.literal_value = lit;
        t.template_done = done;
        return t;
    endfunction

    function automatic token_t mk_cap(logic [GROUP_BITS-1:0] grp, logic done);
        token_t                 t;
        logic [GROUP_BITS+15:0] ext;
        ext = {16'b0, grp};
        t = '0;
        t.token_kind = TOK_CAPTURE;
        t.group_number = ext[15:0];
        t.template_done = done;
        return t;
    endfunction

    function automatic token_t mk_err(logic [1:0] kind, logic done);
        token_t t;
        t = '0;
        t.token_kind = TOK_ERROR;
        t.error_kind = kind;
        t.template_done = done;
        return t;
    endfunction

    // Character classes.
    assign c = item.template_byte;
    assign fin = item.final_byte;

    always_comb
    begin
        is_digit = c inside {[8'h30:8'h39]};
        is_name = is_digit || (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UNDER);
    end

    // Accumulate one decimal digit: acc * 10 + d as shift-add, then saturate.
    assign digit_val = GROUP_BITS'(c - CH_ZERO);
    assign digit_ext = (GROUP_BITS + 4)'(c[3:0]);
    assign acc_ext   = (GROUP_BITS + 4)'(acc_reg);
    assign sum_wide  = (acc_ext << 3) + (acc_ext << 1) + digit_ext;
    assign acc_sum   = (|sum_wide[GROUP_BITS+3:GROUP_BITS]) ? '1 : sum_wide[GROUP_BITS-1:0];

    // Next mode, accumulator and emitted tokens.
    always_comb
    begin
        mode_next = mode_reg;
        acc_next = acc_reg;
        push = '0;
        case (mode_reg)
            MODE_DOLLAR:
            begin
                if (c == CH_DOLLAR)
                begin
                    push.count = 2'd1;
                    push.first = mk_lit(CH_DOLLAR, fin);
                    mode_next = MODE_LIT;
                end
                else if (is_digit)
                begin
                    if (fin)
                    begin
                        push.count = 2'd1;
                        push.first = mk_cap(digit_val, 1'b1);
                        mode_next = MODE_LIT;
                        acc_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_NUM;
                        acc_next = digit_val;
                    end
                end
                else if (c == CH_LBRACE)
                begin
                    acc_next = '0;
                    if (fin)
                    begin
                        push.count = 2'd1;
                        push.first = mk_err(ERR_VARIABLE, 1'b1);
                        mode_next = MODE_LIT;
                    end
                    else
                    begin
                        mode_next = MODE_BSTART;
                    end
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = mk_err(is_name ? ERR_NAMED : ERR_VARIABLE, fin);
                    mode_next = fin ? MODE_LIT : MODE_DROP;
                    acc_next = '0;
                end
            end
            MODE_NUM:
            begin
                if (is_digit)
                begin
                    if (fin)
                    begin
                        push.count = 2'd1;
                        push.first = mk_cap(acc_sum, 1'b1);
                        mode_next = MODE_LIT;
                        acc_next = '0;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                    end
                end
                else
                begin
                    // The reference ends here; the terminating byte is then
                    // handled as in literal mode.
                    push.count = 2'd2;
                    push.first = mk_cap(acc_reg, 1'b0);
                    acc_next = '0;
                    mode_next = MODE_LIT;
                    if (c == CH_DOLLAR)
                    begin
                        if (fin)
                        begin
                            push.second = mk_err(ERR_VARIABLE, 1'b1);
                        end
                        else
                        begin
                            push.count = 2'd1;
                            mode_next = MODE_DOLLAR;
                        end
                    end
                    else
                    begin
                        push.second = mk_lit(c, fin);
                    end
                end
            end
            MODE_BSTART:
            begin
                if (c == CH_RBRACE || c == CH_NUL)
                begin
                    push.count = 2'd1;
                    push.first = mk_err(ERR_VARIABLE, fin);
                    mode_next = fin ? MODE_LIT : MODE_DROP;
                    acc_next = '0;
                end
                else if ((is_digit || is_name) && !fin)
                begin
                    mode_next = is_digit ? MODE_BNUM : MODE_BNAME;
                    acc_next = is_digit ? acc_sum : acc_reg;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = mk_err(ERR_BRACE, fin);
                    mode_next = fin ? MODE_LIT : MODE_DROP;
                    acc_next = '0;
                end
            end
            MODE_BNAME:
            begin
                if (!(is_name && !fin))
                begin
                    push.count = 2'd1;
                    push.first = mk_err((c == CH_RBRACE) ? ERR_NAMED : ERR_BRACE, fin);
                    mode_next = fin ? MODE_LIT : MODE_DROP;
                    acc_next = '0;
                end
            end
            MODE_BNUM:
            begin
                if (c == CH_RBRACE)
                begin
                    push.count = 2'd1;
                    push.first = mk_cap(acc_reg, fin);
                    mode_next = MODE_LIT;
                    acc_next = '0;
                end
                else if (is_digit && !fin)
                begin
                    acc_next = acc_sum;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = mk_err(ERR_BRACE, fin);
                    mode_next = fin ? MODE_LIT : MODE_DROP;
                    acc_next = '0;
                end
            end
            MODE_DROP:
            begin
                if (fin)
                begin
                    mode_next = MODE_LIT;
                    acc_next = '0;
                end
            end
            default:
            begin
                // Literal mode, and any unused mode code.
                acc_next = '0;
                mode_next = MODE_LIT;
                if (c == CH_DOLLAR)
                begin
                    if (fin)
                    begin
                        push.count = 2'd1;
                        push.first = mk_err(ERR_VARIABLE, 1'b1);
                    end
                    else
                    begin
                        mode_next = MODE_DOLLAR;
                    end
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = mk_lit(c, fin);
                end
            end
        endcase
        if (!fire)
        begin
            push.count = 2'd0;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LIT;
            acc_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            acc_reg <= acc_next;
        end
    end

    // A final character always leaves the parser in literal mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && fin |=> mode_reg == MODE_LIT)
        else $error("parser not back in literal mode after a final byte");

    // Nothing is emitted while the rest of a failed template is dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && mode_reg == MODE_DROP |-> push.count == 2'd0)
        else $error("token emitted in drop mode");

    // A pair of tokens always starts with the capture that the byte ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.token_kind == TOK_CAPTURE
                               && push.first.template_done == 1'b0)
        else $error("bad token pair");

endmodule

>>> design/rtt_queue.sv
// ----------------------------------------------------------------------------
// rtt_queue: token queue in front of the output port
// A small circular buffer that takes up to two tokens per cycle from the
// parser and hands one token per beat to the output channel.
// ----------------------------------------------------------------------------
module rtt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  rtt_pkg::push_t  push,
    output logic            has_room,
    output logic            token_valid,
    input  logic            token_ready,
    output rtt_pkg::token_t token
);
    import rtt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    // Room for a full pair is checked against the registered count only.
    assign has_room = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign token_valid = count_reg != '0;
    assign token = mem[rd_ptr_reg];
    assign pop = token_valid && token_ready;

    // Pointer and fill count update.
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    // The parser never pushes more than the queue can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> (CNT_W + 1)'(count_reg) + (CNT_W + 1)'(push.count)
                               <= (CNT_W + 1)'(QUEUE_DEPTH))
        else $error("token queue overflow");

    // Fill count tracks pushes and pops exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + CNT_W'($past(push.count))
                              - CNT_W'($past(pop)))
        else $error("token queue count mismatch");

    // A waiting token holds still until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid && $stable(token))
        else $error("token changed while waiting");

endmodule

>>> design/replacement_template_tokenizer.sv
// ----------------------------------------------------------------------------
// replacement_template_tokenizer: regex replacement template tokenizer
// Turns a byte stream of replacement templates into literal, capture group
// and error tokens.
// ----------------------------------------------------------------------------
// The block takes one template byte per cycle. Each byte is registered, parsed
// once the queue has room for two tokens, and its tokens written into a
// four-entry queue that feeds the output port. Most bytes give one token; a
// byte that ends an unbraced $N reference gives two, and bytes inside a
// reference or after an error give none. The input keeps accepting a byte
// every cycle as long as the queue has room for two tokens, so the sustained
// rate is set by the output port, which delivers one token per beat.
module replacement_template_tokenizer #(
    parameter int GROUP_BITS = rtt_pkg::GROUP_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               template_valid,
    output logic               template_ready,
    input  rtt_pkg::template_t template,
    output logic               token_valid,
    input  logic               token_ready,
    output rtt_pkg::token_t    token
);
    import rtt_pkg::*;

    template_t  in_data_reg;
    logic       in_vld_reg;
    logic       in_vld_next;
    logic       has_room;
    logic       fire;
    push_t      push;

    // Input register: free when empty or when its byte is parsed this cycle.
    assign fire = in_vld_reg && has_room;
    assign template_ready = !in_vld_reg || has_room;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (template_valid && template_ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (template_valid && template_ready)
        begin
            in_data_reg <= template;
        end
    end

    // Parser.
    rtt_parse #(
        .GROUP_BITS (GROUP_BITS)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_data_reg),
        .push  (push)
    );

    // Token queue toward the output port.
    rtt_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .has_room    (has_room),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

endmodule
